/* rtl/rfw_pkg.sv */
// Shared constants and types for the rectangle fill write generator.
package rfw_pkg;

  localparam int MAX_SURFACE_DIM = 4096;
  localparam int DIM_W           = $clog2(MAX_SURFACE_DIM + 1);
  localparam int OFFSET_W        = 28;
  localparam int COLOUR_W        = 32;
  localparam int PITCH_W         = 16;
  localparam int COORD_W         = 16;
  localparam int BYTES_W         = 3;
  localparam int PADDR_W         = 5;
  localparam int PDATA_W         = 32;

  // action codes
  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  // pixel_format codes
  localparam logic [2:0] FMT_ARGB32 = 3'd0;
  localparam logic [2:0] FMT_RGB24  = 3'd1;
  localparam logic [2:0] FMT_A8     = 3'd2;
  localparam logic [2:0] FMT_A1     = 3'd3;
  localparam logic [2:0] FMT_RGB565 = 3'd4;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_SURFACE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SURFACE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_ROW_PITCH      = 3'd2;
  localparam logic [2:0] REG_PIXEL_FORMAT   = 3'd3;
  localparam logic [2:0] REG_RGB24_ORDER    = 3'd4;

  // one command word as held in the input register
  typedef struct packed {
    logic                      action;
    logic                      whole_surface;
    logic signed [COORD_W-1:0] rect_left;
    logic signed [COORD_W-1:0] rect_top;
    logic [COORD_W-1:0]        rect_width;
    logic [COORD_W-1:0]        rect_height;
    logic [COLOUR_W-1:0]       fill_colour;
  } cmd_word_t;

endpackage

/* rtl/rfw_if.sv */
// Valid/ready channel interfaces for command and pixel write words.
interface rfw_cmd_if;
  logic                              valid;
  logic                              ready;
  logic                              action;
  logic                              whole_surface;
  logic signed [rfw_pkg::COORD_W-1:0] rect_left;
  logic signed [rfw_pkg::COORD_W-1:0] rect_top;
  logic [rfw_pkg::COORD_W-1:0]       rect_width;
  logic [rfw_pkg::COORD_W-1:0]       rect_height;
  logic [rfw_pkg::COLOUR_W-1:0]      fill_colour;

  modport source (output valid, action, whole_surface, rect_left, rect_top, rect_width,
                  rect_height, fill_colour, input ready);
  modport sink (input valid, action, whole_surface, rect_left, rect_top, rect_width,
                rect_height, fill_colour, output ready);
endinterface

interface rfw_wr_if;
  logic                              valid;
  logic                              ready;
  logic [rfw_pkg::OFFSET_W-1:0]      write_offset;
  logic [rfw_pkg::COLOUR_W-1:0]      write_data;
  logic [rfw_pkg::BYTES_W-1:0]       write_bytes;
  logic                              last_write;

  modport source (output valid, write_offset, write_data, write_bytes, last_write,
                  input ready);
  modport sink (input valid, write_offset, write_data, write_bytes, last_write,
                output ready);
endinterface

/* rtl/rect_fill_write_generator.sv */
// Solid rectangle fill engine: clips a rectangle and issues one pixel write per advance.
// A command word is taken into the input register; when an advance moves on from there,
//   its pixel write is loaded into the output register, where the write side takes it.
// Throughput: one command word per cycle; the output register and the input register
//   each stall only while the write side holds ready low.
// Reset (rst, synchronous, active high): configuration and walker registers to zero, no
//   fill in progress, both pipeline registers empty.
module rect_fill_write_generator (
  input  logic                        clk,
  input  logic                        rst,
  rfw_cmd_if.sink                     cmd,
  rfw_wr_if.source                    wr,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rfw_pkg::PADDR_W-1:0] paddr,
  input  logic [rfw_pkg::PDATA_W-1:0] pwdata,
  output logic [rfw_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int DW = rfw_pkg::DIM_W;
  localparam int OW = rfw_pkg::OFFSET_W;
  localparam int CW = rfw_pkg::COORD_W + 2;   // room for left + width, signed

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [DW-1:0]                surface_width;
  logic [DW-1:0]                surface_height;
  logic [rfw_pkg::PITCH_W-1:0]  row_pitch;
  logic [2:0]                   pixel_format;
  logic                         rgb24_msb_first;
  logic                         cfg_write;
  logic [2:0]                   cfg_index;

  assign pready    = 1'b1;
  assign cfg_index = paddr[rfw_pkg::PADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      surface_width   <= '0;
      surface_height  <= '0;
      row_pitch       <= '0;
      pixel_format    <= rfw_pkg::FMT_ARGB32;
      rgb24_msb_first <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rfw_pkg::REG_SURFACE_WIDTH:  surface_width   <= pwdata[DW-1:0];
        rfw_pkg::REG_SURFACE_HEIGHT: surface_height  <= pwdata[DW-1:0];
        rfw_pkg::REG_ROW_PITCH:      row_pitch       <= pwdata[rfw_pkg::PITCH_W-1:0];
        rfw_pkg::REG_PIXEL_FORMAT:   pixel_format    <= pwdata[2:0];
        rfw_pkg::REG_RGB24_ORDER:    rgb24_msb_first <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_index)
      rfw_pkg::REG_SURFACE_WIDTH:  prdata[DW-1:0]               = surface_width;
      rfw_pkg::REG_SURFACE_HEIGHT: prdata[DW-1:0]               = surface_height;
      rfw_pkg::REG_ROW_PITCH:      prdata[rfw_pkg::PITCH_W-1:0] = row_pitch;
      rfw_pkg::REG_PIXEL_FORMAT:   prdata[2:0]                  = pixel_format;
      rfw_pkg::REG_RGB24_ORDER:    prdata[0]                    = rgb24_msb_first;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: input register (s1) feeds the output register.
  // s1 moves whenever the output register is empty or being drained.
  // ---------------------------------------------------------------------------
  rfw_pkg::cmd_word_t s1;
  logic               s1_valid;
  logic               s1_move;
  logic               out_valid;

  assign s1_move   = s1_valid && (!out_valid || wr.ready);
  assign cmd.ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      s1.action        <= cmd.action;
      s1.whole_surface <= cmd.whole_surface;
      s1.rect_left     <= cmd.rect_left;
      s1.rect_top      <= cmd.rect_top;
      s1.rect_width    <= cmd.rect_width;
      s1.rect_height   <= cmd.rect_height;
      s1.fill_colour   <= cmd.fill_colour;
    end
  end

  // ---------------------------------------------------------------------------
  // Fill walker state
  // ---------------------------------------------------------------------------
  logic                         fill_active, fill_active_next;
  logic [DW-1:0]                clip_left, clip_left_next;
  logic [DW-1:0]                clip_right_end, clip_right_end_next;
  logic [DW-1:0]                clip_bottom_end, clip_bottom_end_next;
  logic [DW-1:0]                cur_column, cur_column_next;
  logic [DW-1:0]                cur_row, cur_row_next;
  logic [OW-1:0]                row_base_offset, row_base_offset_next;
  logic [rfw_pkg::COLOUR_W-1:0] held_colour, held_colour_next;
  logic [rfw_pkg::BYTES_W-1:0]  held_bytes, held_bytes_next;
  logic [rfw_pkg::PITCH_W-1:0]  held_pitch, held_pitch_next;

  // Clip: surface size clamped to the max dimension, rectangle edges in signed math.
  logic [DW-1:0]        sw_clamped, sh_clamped;
  logic signed [CW-1:0] rl, rt, rr, rb, x0, y0, x1, y1;
  logic                 clip_empty;
  logic                 fmt_fills;
  logic [2:0]           fmt_bytes;
  logic [rfw_pkg::COLOUR_W-1:0] fmt_colour;
  logic [DW+rfw_pkg::PITCH_W-1:0] top_product;
  logic [DW-1:0]        top_row;

  always_comb begin
    sw_clamped = (surface_width  > DW'(rfw_pkg::MAX_SURFACE_DIM)) ?
                 DW'(rfw_pkg::MAX_SURFACE_DIM) : surface_width;
    sh_clamped = (surface_height > DW'(rfw_pkg::MAX_SURFACE_DIM)) ?
                 DW'(rfw_pkg::MAX_SURFACE_DIM) : surface_height;
    rl = CW'(s1.rect_left);
    rt = CW'(s1.rect_top);
    rr = rl + signed'(CW'({2'b00, s1.rect_width}));
    rb = rt + signed'(CW'({2'b00, s1.rect_height}));
    if (s1.whole_surface) begin
      x0 = '0;
      y0 = '0;
      x1 = signed'(CW'(sw_clamped));
      y1 = signed'(CW'(sh_clamped));
    end else begin
      x0 = (rl > 0) ? rl : '0;
      y0 = (rt > 0) ? rt : '0;
      x1 = (rr < signed'(CW'(sw_clamped))) ? rr : signed'(CW'(sw_clamped));
      y1 = (rb < signed'(CW'(sh_clamped))) ? rb : signed'(CW'(sh_clamped));
    end
    clip_empty = (x0 >= x1) || (y0 >= y1);
  end

  // Top row fits DW bits whenever the clip is not empty; the product runs
  // in parallel with the clip compares.
  always_comb begin
    if (s1.whole_surface || s1.rect_top[rfw_pkg::COORD_W-1]) begin
      top_row = '0;
    end else begin
      top_row = s1.rect_top[DW-1:0];
    end
    top_product = top_row * row_pitch;
  end

  // Colour formatting per pixel format
  always_comb begin
    fmt_fills  = 1'b1;
    fmt_bytes  = 3'd4;
    fmt_colour = s1.fill_colour;
    unique case (pixel_format)
      rfw_pkg::FMT_ARGB32: begin
        fmt_bytes  = 3'd4;
        fmt_colour = s1.fill_colour;
      end
      rfw_pkg::FMT_RGB24: begin
        fmt_bytes = 3'd3;
        if (rgb24_msb_first) begin
          fmt_colour = {8'h00, s1.fill_colour[7:0], s1.fill_colour[15:8],
                        s1.fill_colour[23:16]};
        end else begin
          fmt_colour = {8'h00, s1.fill_colour[23:0]};
        end
      end
      rfw_pkg::FMT_A8: begin
        fmt_bytes  = 3'd1;
        fmt_colour = {24'h0, s1.fill_colour[7:0]};
      end
      rfw_pkg::FMT_RGB565: begin
        fmt_bytes  = 3'd2;
        fmt_colour = {16'h0, s1.fill_colour[15:0]};
      end
      default: fmt_fills = 1'b0;   // a1 and unused codes: no fill
    endcase
  end

  // Advance: current pixel and walker step
  logic [DW+rfw_pkg::BYTES_W-1:0] col_bytes;
  logic [OW-1:0]                  pix_offset;
  logic [DW:0]                    col_inc, row_inc;
  logic                           is_last;
  logic                           do_start, do_advance;

  assign do_start   = s1_move && (s1.action == rfw_pkg::ACT_START);
  assign do_advance = s1_move && (s1.action == rfw_pkg::ACT_ADVANCE) && fill_active;

  always_comb begin
    col_bytes  = cur_column * held_bytes;
    pix_offset = row_base_offset + OW'(col_bytes);
    col_inc    = {1'b0, cur_column} + 1'b1;
    row_inc    = {1'b0, cur_row} + 1'b1;
    is_last    = (col_inc == {1'b0, clip_right_end}) && (row_inc == {1'b0, clip_bottom_end});
  end

  always_comb begin
    fill_active_next     = fill_active;
    clip_left_next       = clip_left;
    clip_right_end_next  = clip_right_end;
    clip_bottom_end_next = clip_bottom_end;
    cur_column_next      = cur_column;
    cur_row_next         = cur_row;
    row_base_offset_next = row_base_offset;
    held_colour_next     = held_colour;
    held_bytes_next      = held_bytes;
    held_pitch_next      = held_pitch;
    if (do_start) begin
      // a new command always replaces a fill in progress
      fill_active_next = !clip_empty && fmt_fills;
      if (!clip_empty && fmt_fills) begin
        clip_left_next       = x0[DW-1:0];
        clip_right_end_next  = x1[DW-1:0];
        clip_bottom_end_next = y1[DW-1:0];
        cur_column_next      = x0[DW-1:0];
        cur_row_next         = y0[DW-1:0];
        row_base_offset_next = top_product[OW-1:0];
        held_colour_next     = fmt_colour;
        held_bytes_next      = fmt_bytes;
        held_pitch_next      = row_pitch;
      end
    end else if (do_advance) begin
      if (col_inc >= {1'b0, clip_right_end}) begin
        cur_column_next      = clip_left;
        cur_row_next         = row_inc[DW-1:0];
        row_base_offset_next = row_base_offset + OW'(held_pitch);
        if (row_inc >= {1'b0, clip_bottom_end}) begin
          fill_active_next = 1'b0;
        end
      end else begin
        cur_column_next = col_inc[DW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_active <= 1'b0;
    end else begin
      fill_active <= fill_active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_left       <= '0;
      clip_right_end  <= '0;
      clip_bottom_end <= '0;
      cur_column      <= '0;
      cur_row         <= '0;
      row_base_offset <= '0;
      held_colour     <= '0;
      held_bytes      <= '0;
      held_pitch      <= '0;
    end else begin
      clip_left       <= clip_left_next;
      clip_right_end  <= clip_right_end_next;
      clip_bottom_end <= clip_bottom_end_next;
      cur_column      <= cur_column_next;
      cur_row         <= cur_row_next;
      row_base_offset <= row_base_offset_next;
      held_colour     <= held_colour_next;
      held_bytes      <= held_bytes_next;
      held_pitch      <= held_pitch_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || wr.ready) begin
      out_valid <= do_advance;
    end
  end

  always_ff @(posedge clk) begin
    if (do_advance) begin
      wr.write_offset <= pix_offset;
      wr.write_data   <= held_colour;
      wr.write_bytes  <= held_bytes;
      wr.last_write   <= is_last;
    end
  end

  assign wr.valid = out_valid;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_walker_in_bounds: assert property (@(posedge clk) disable iff (rst)
    fill_active |-> (cur_column < clip_right_end) && (cur_column >= clip_left) &&
                    (cur_row < clip_bottom_end))
    else $error("walker outside clipped rectangle");

  a_last_ends_fill: assert property (@(posedge clk) disable iff (rst)
    do_advance && is_last |=> !fill_active)
    else $error("fill still active after last write");

  a_bytes_nonzero: assert property (@(posedge clk) disable iff (rst)
    do_advance |-> (held_bytes == 3'd1) || (held_bytes == 3'd2) ||
                   (held_bytes == 3'd3) || (held_bytes == 3'd4))
    else $error("pixel write with bad byte count");

  a_ready_when_out_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> cmd.ready)
    else $error("command stalled while output register free");

endmodule
